/* rtl/elx_pkg.sv */
// ----------------------------------------------------------------------------
// elx_pkg
// Shared types and constants of the expression lexer: byte classes, scan
// modes, keyword prefix codes, token kinds and the queue entry formats.
// ----------------------------------------------------------------------------
package elx_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_TOKEN_LEN     = 255;
    localparam logic [7:0] LEN_CAP   = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);
    localparam int ITEM_Q_DEPTH      = 2;
    localparam int RES_Q_DEPTH       = 2;

    typedef enum logic [3:0] {
        C_BLANK, C_ZERO, C_LETTER, C_DIGIT, C_DOT,
        C_LT, C_GT, C_EQ, C_BANG, C_AMP, C_BAR,
        C_SINGLE, C_OTHER
    } t_cls;

    typedef enum logic [3:0] {
        CH_NONE, CH_I, CH_E, CH_R, CH_F, CH_L, CH_S, CH_T, CH_U, CH_N
    } t_kch;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_FRAC, M_LT, M_GT, M_EQ, M_BANG, M_AMP, M_BAR
    } t_mode;

    typedef enum logic [3:0] {
        KW_NONE, KW_I, KW_IF, KW_E, KW_EL, KW_ELS, KW_ELSE,
        KW_R, KW_RE, KW_RET, KW_RETU, KW_RETUR, KW_RETURN
    } t_kw;

    typedef enum logic [4:0] {
        K_ERROR, K_END, K_IDENT, K_NUMBER, K_IF, K_ELSE, K_RETURN,
        K_LE, K_GE, K_EQEQ, K_NE, K_ANDAND, K_OROR,
        K_LT, K_GT, K_ASSIGN, K_BANG, K_SEMI, K_COMMA, K_SLASH,
        K_MINUS, K_PLUS, K_STAR, K_LBRACE, K_RBRACE, K_LPAREN, K_RPAREN
    } t_kind;

    typedef struct packed {
        t_cls        cls;
        t_kch        kch;
        t_kind       skind;
        logic [15:0] pos;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  len;
    } t_tok;

    typedef struct packed {
        t_tok tok;
        logic last;
    } t_res;

endpackage

/* rtl/elx_fifo.sv */
// ----------------------------------------------------------------------------
// elx_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module elx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_wr) - CW'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

/* rtl/elx_front.sv */
// ----------------------------------------------------------------------------
// elx_front
// Byte classifier and stream position counter.
// ----------------------------------------------------------------------------
module elx_front #(
    parameter int POSITION_BITS = elx_pkg::POSITION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_text_byte,
    input  logic          i_take,
    output elx_pkg::t_item o_item
);
    import elx_pkg::*;

    logic [POSITION_BITS-1:0] r_pos;
    logic [15:0]              pos16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_take) begin
            if (i_text_byte == 8'h00) begin
                r_pos <= '0;
            end else if (r_pos != {POSITION_BITS{1'b1}}) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    generate
        if (POSITION_BITS > 16) begin : g_sat
            assign pos16 = (|r_pos[POSITION_BITS-1:16]) ? 16'hFFFF : r_pos[15:0];
        end else begin : g_ext
            assign pos16 = 16'(r_pos);
        end
    endgenerate

    always_comb begin
        o_item.pos   = pos16;
        o_item.kch   = CH_NONE;
        o_item.skind = K_ERROR;
        case (i_text_byte) inside
            8'h00:                               o_item.cls = C_ZERO;
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: o_item.cls = C_BLANK;
            [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: o_item.cls = C_LETTER;
            [8'h30:8'h39]:                       o_item.cls = C_DIGIT;
            8'h2E:                               o_item.cls = C_DOT;
            8'h3C:                               o_item.cls = C_LT;
            8'h3E:                               o_item.cls = C_GT;
            8'h3D:                               o_item.cls = C_EQ;
            8'h21:                               o_item.cls = C_BANG;
            8'h26:                               o_item.cls = C_AMP;
            8'h7C:                               o_item.cls = C_BAR;
            8'h3B, 8'h2C, 8'h2F, 8'h2D, 8'h2B, 8'h2A,
            8'h7B, 8'h7D, 8'h28, 8'h29:          o_item.cls = C_SINGLE;
            default:                             o_item.cls = C_OTHER;
        endcase
        case (i_text_byte)
            8'h69:   o_item.kch = CH_I;
            8'h65:   o_item.kch = CH_E;
            8'h72:   o_item.kch = CH_R;
            8'h66:   o_item.kch = CH_F;
            8'h6C:   o_item.kch = CH_L;
            8'h73:   o_item.kch = CH_S;
            8'h74:   o_item.kch = CH_T;
            8'h75:   o_item.kch = CH_U;
            8'h6E:   o_item.kch = CH_N;
            default: o_item.kch = CH_NONE;
        endcase
        case (i_text_byte)
            8'h3B:   o_item.skind = K_SEMI;
            8'h2C:   o_item.skind = K_COMMA;
            8'h2F:   o_item.skind = K_SLASH;
            8'h2D:   o_item.skind = K_MINUS;
            8'h2B:   o_item.skind = K_PLUS;
            8'h2A:   o_item.skind = K_STAR;
            8'h7B:   o_item.skind = K_LBRACE;
            8'h7D:   o_item.skind = K_RBRACE;
            8'h28:   o_item.skind = K_LPAREN;
            8'h29:   o_item.skind = K_RPAREN;
            default: o_item.skind = K_ERROR;
        endcase
    end

endmodule

/* rtl/elx_back.sv */
// ----------------------------------------------------------------------------
// elx_back
// Token scanner: holds the pending token, closes it and emits up to two
// tokens per classified byte, one result transfer per cycle unless i_full.
// ----------------------------------------------------------------------------
module elx_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  elx_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_full,
    output logic           o_push,
    output elx_pkg::t_res  o_res
);
    import elx_pkg::*;

    t_mode       r_mode, n_mode;
    t_kw         r_kw, n_kw;
    logic [15:0] r_pstart, n_pstart;
    logic [7:0]  r_plen, n_plen;
    logic        r_second, n_second;

    logic  consumed, op_mode, has_flush, has_new;
    t_kind two_kind, flush_kind;
    t_tok  tok_flush, tok_new;

    function automatic t_kw kw_step(input t_kw kw, input t_kch ch);
        t_kw nxt;
        nxt = KW_NONE;
        unique case (kw)
            KW_I:     if (ch == CH_F) nxt = KW_IF;
            KW_E:     if (ch == CH_L) nxt = KW_EL;
            KW_EL:    if (ch == CH_S) nxt = KW_ELS;
            KW_ELS:   if (ch == CH_E) nxt = KW_ELSE;
            KW_R:     if (ch == CH_E) nxt = KW_RE;
            KW_RE:    if (ch == CH_T) nxt = KW_RET;
            KW_RET:   if (ch == CH_U) nxt = KW_RETU;
            KW_RETU:  if (ch == CH_R) nxt = KW_RETUR;
            KW_RETUR: if (ch == CH_N) nxt = KW_RETURN;
            default:  nxt = KW_NONE;
        endcase
        return nxt;
    endfunction

    // token decode
    always_comb begin
        consumed   = 1'b0;
        op_mode    = 1'b0;
        two_kind   = K_ERROR;
        flush_kind = K_ERROR;
        unique case (r_mode)
            M_IDENT: begin
                consumed = (i_item.cls == C_LETTER) || (i_item.cls == C_DIGIT);
                unique case (r_kw)
                    KW_IF:     flush_kind = K_IF;
                    KW_ELSE:   flush_kind = K_ELSE;
                    KW_RETURN: flush_kind = K_RETURN;
                    default:   flush_kind = K_IDENT;
                endcase
            end
            M_INT: begin
                consumed   = (i_item.cls == C_DIGIT) || (i_item.cls == C_DOT);
                flush_kind = K_NUMBER;
            end
            M_FRAC: begin
                consumed   = (i_item.cls == C_DIGIT);
                flush_kind = K_NUMBER;
            end
            M_LT: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_EQ);
                two_kind = K_LE; flush_kind = K_LT;
            end
            M_GT: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_EQ);
                two_kind = K_GE; flush_kind = K_GT;
            end
            M_EQ: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_EQ);
                two_kind = K_EQEQ; flush_kind = K_ASSIGN;
            end
            M_BANG: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_EQ);
                two_kind = K_NE; flush_kind = K_BANG;
            end
            M_AMP: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_AMP);
                two_kind = K_ANDAND; flush_kind = K_ERROR;
            end
            M_BAR: begin
                op_mode = 1'b1; consumed = (i_item.cls == C_BAR);
                two_kind = K_OROR; flush_kind = K_ERROR;
            end
            default: begin
                consumed = 1'b0;
            end
        endcase

        has_flush = !consumed && (r_mode != M_IDLE);
        tok_flush = '{kind: flush_kind, start: r_pstart, len: r_plen};
        has_new   = 1'b0;
        tok_new   = '{kind: K_ERROR, start: i_item.pos, len: 8'd1};
        if (consumed) begin
            if (op_mode) begin
                has_new = 1'b1;
                tok_new = '{kind: two_kind, start: r_pstart, len: 8'd2};
            end
        end else begin
            case (i_item.cls) inside
                C_ZERO: begin
                    has_new = 1'b1;
                    tok_new = '{kind: K_END, start: i_item.pos, len: 8'd0};
                end
                C_SINGLE: begin
                    has_new = 1'b1;
                    tok_new = '{kind: i_item.skind, start: i_item.pos, len: 8'd1};
                end
                C_DOT, C_OTHER: begin
                    has_new = 1'b1;
                end
                default: has_new = 1'b0;
            endcase
        end
    end

    // next scan state
    always_comb begin
        n_mode   = r_mode;
        n_kw     = r_kw;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        if (!consumed) begin
            if (has_flush) begin
                n_mode = M_IDLE;
                n_kw   = KW_NONE;
                n_plen = '0;
            end
            unique case (i_item.cls)
                C_ZERO: begin
                    n_mode   = M_IDLE;
                    n_kw     = KW_NONE;
                    n_pstart = '0;
                    n_plen   = '0;
                end
                C_LETTER, C_DIGIT, C_LT, C_GT, C_EQ, C_BANG, C_AMP, C_BAR: begin
                    n_pstart = i_item.pos;
                    n_plen   = 8'd1;
                    n_kw     = KW_NONE;
                    unique case (i_item.cls)
                        C_LETTER: begin
                            n_mode = M_IDENT;
                            if (i_item.kch == CH_I)      n_kw = KW_I;
                            else if (i_item.kch == CH_E) n_kw = KW_E;
                            else if (i_item.kch == CH_R) n_kw = KW_R;
                        end
                        C_DIGIT: n_mode = M_INT;
                        C_LT:    n_mode = M_LT;
                        C_GT:    n_mode = M_GT;
                        C_EQ:    n_mode = M_EQ;
                        C_BANG:  n_mode = M_BANG;
                        C_AMP:   n_mode = M_AMP;
                        default: n_mode = M_BAR;
                    endcase
                end
                default: ;
            endcase
        end else if (op_mode) begin
            n_mode = M_IDLE;
            n_plen = '0;
        end else begin
            if (r_plen < LEN_CAP) n_plen = r_plen + 1'b1;
            if (r_mode == M_IDENT) n_kw = kw_step(r_kw, i_item.kch);
            if ((r_mode == M_INT) && (i_item.cls == C_DOT)) n_mode = M_FRAC;
        end
    end

    // result transfer and item release
    always_comb begin
        n_second = r_second;
        o_pop    = 1'b0;
        o_push   = 1'b0;
        o_res    = '{tok: tok_flush, last: 1'b0};
        if (i_valid) begin
            if (has_flush && has_new && !r_second) begin
                o_push = !i_full;
                if (o_push) n_second = 1'b1;
            end else if (!has_flush && !has_new) begin
                o_pop = 1'b1;
            end else begin
                o_res  = '{tok: (has_new ? tok_new : tok_flush), last: 1'b1};
                o_push = !i_full;
                o_pop  = o_push;
                if (o_pop) n_second = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_kw     <= KW_NONE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
            if (o_pop) begin
                r_mode   <= n_mode;
                r_kw     <= n_kw;
                r_pstart <= n_pstart;
                r_plen   <= n_plen;
            end
        end
    end

endmodule

/* rtl/expression_lexer.sv */
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming scanner: one source byte per transfer in, tokens out.
// A token goes out through the item queue and then the result queue.
// Throughput: one byte per cycle while neither queue is full; a byte that
// both closes a token and yields one is held in the scanner for two writes,
// as the single result queue write port takes one token at a time.
// Reset: synchronous, active low; clears both queues, scan state and position.
// ----------------------------------------------------------------------------
module expression_lexer #(
    parameter int POSITION_BITS = elx_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_text_byte,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [7:0]  o_token_length,
    output logic        o_last_of_run
);
    import elx_pkg::*;

    logic  take;
    t_item item_in, item_q;
    logic  q_empty, q_pop;
    logic  res_full, res_push;
    t_res  res_in, res_q;

    assign take = push && !full;

    elx_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text_byte(i_text_byte),
        .i_take     (take),
        .o_item     (item_in)
    );

    elx_fifo #(
        .WIDTH($bits(t_item)),
        .DEPTH(ITEM_Q_DEPTH)
    ) u_item_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (take),
        .i_wdata(item_in),
        .i_rd   (q_pop),
        .o_rdata(item_q),
        .o_full (full),
        .o_empty(q_empty)
    );

    elx_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(!q_empty),
        .i_item (item_q),
        .o_pop  (q_pop),
        .i_full (res_full),
        .o_push (res_push),
        .o_res  (res_in)
    );

    elx_fifo #(
        .WIDTH($bits(t_res)),
        .DEPTH(RES_Q_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (res_push),
        .i_wdata(res_in),
        .i_rd   (pop && !empty),
        .o_rdata(res_q),
        .o_full (res_full),
        .o_empty(empty)
    );

    assign o_token_kind   = res_q.tok.kind;
    assign o_token_start  = res_q.tok.start;
    assign o_token_length = res_q.tok.len;
    assign o_last_of_run  = res_q.last;

endmodule

/* verif/token_checker.sv */
// ----------------------------------------------------------------------------
// token_checker
// Watches both queue ports of the expression lexer. Every byte transfer is
// run through a scanner model kept here, and the tokens it yields are
// queued as due. Every token transfer is compared field by field against
// the oldest due token. The mismatch count and the number of tokens still
// due are handed to the testbench top.
// ----------------------------------------------------------------------------
module token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_text_byte,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [4:0]  i_token_kind,
    input  logic [15:0] i_token_start,
    input  logic [7:0]  i_token_length,
    input  logic        i_last_of_run,
    output int          o_mismatches,
    output int          o_tokens_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import elx_pkg::*;

    t_mode       scan_mode;
    t_kw         kw_seen;
    logic [15:0] tok_start;
    logic [7:0]  tok_len;
    logic [15:0] byte_pos;
    t_res        step_tokens[$];
    t_res        tokens_due[$];

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C
            || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic t_kind single_op(input logic [7:0] c);
        case (c)
            8'h3B: return K_SEMI;
            8'h2C: return K_COMMA;
            8'h2F: return K_SLASH;
            8'h2D: return K_MINUS;
            8'h2B: return K_PLUS;
            8'h2A: return K_STAR;
            8'h7B: return K_LBRACE;
            8'h7D: return K_RBRACE;
            8'h28: return K_LPAREN;
            8'h29: return K_RPAREN;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic t_kw kw_after(input t_kw k, input logic [7:0] c);
        case (k)
            KW_I:     return (c == 8'h66) ? KW_IF     : KW_NONE;
            KW_E:     return (c == 8'h6C) ? KW_EL     : KW_NONE;
            KW_EL:    return (c == 8'h73) ? KW_ELS    : KW_NONE;
            KW_ELS:   return (c == 8'h65) ? KW_ELSE   : KW_NONE;
            KW_R:     return (c == 8'h65) ? KW_RE     : KW_NONE;
            KW_RE:    return (c == 8'h74) ? KW_RET    : KW_NONE;
            KW_RET:   return (c == 8'h75) ? KW_RETU   : KW_NONE;
            KW_RETU:  return (c == 8'h72) ? KW_RETUR  : KW_NONE;
            KW_RETUR: return (c == 8'h6E) ? KW_RETURN : KW_NONE;
            default:  return KW_NONE;
        endcase
    endfunction

    function automatic t_kind pair_op(input t_mode m);
        case (m)
            M_LT:    return K_LE;
            M_GT:    return K_GE;
            M_EQ:    return K_EQEQ;
            default: return K_NE;
        endcase
    endfunction

    task automatic clear_scan();
        scan_mode = M_IDLE;
        kw_seen   = KW_NONE;
        tok_start = '0;
        tok_len   = '0;
        byte_pos  = '0;
    endtask

    task automatic put_token(input t_kind kind, input logic [15:0] start,
                             input logic [7:0] len);
        t_res r;
        r.tok.kind  = kind;
        r.tok.start = start;
        r.tok.len   = len;
        r.last      = 1'b0;
        step_tokens.push_back(r);
    endtask

    task automatic open_token(input t_mode m);
        scan_mode = m;
        tok_start = byte_pos;
        tok_len   = 8'd1;
        kw_seen   = KW_NONE;
    endtask

    task automatic lengthen();
        if (tok_len < LEN_CAP)
            tok_len++;
    endtask

    task automatic close_token();
        t_kind kind;
        logic  have;
        have = 1'b1;
        kind = K_ERROR;
        case (scan_mode)
            M_IDENT: begin
                kind = K_IDENT;
                if (kw_seen == KW_IF)
                    kind = K_IF;
                else if (kw_seen == KW_ELSE)
                    kind = K_ELSE;
                else if (kw_seen == KW_RETURN)
                    kind = K_RETURN;
            end
            M_INT, M_FRAC: kind = K_NUMBER;
            M_LT:          kind = K_LT;
            M_GT:          kind = K_GT;
            M_EQ:          kind = K_ASSIGN;
            M_BANG:        kind = K_BANG;
            M_AMP, M_BAR:  kind = K_ERROR;
            default:       have = 1'b0;
        endcase
        if (have) begin
            put_token(kind, tok_start, tok_len);
            scan_mode = M_IDLE;
            kw_seen   = KW_NONE;
            tok_len   = '0;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic taken;
        logic ended;
        taken = 1'b0;
        ended = 1'b0;
        step_tokens.delete();
        case (scan_mode)
            M_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    lengthen();
                    kw_seen = kw_after(kw_seen, c);
                    taken   = 1'b1;
                end
            end
            M_INT: begin
                if (is_num(c)) begin
                    lengthen();
                    taken = 1'b1;
                end else if (c == 8'h2E) begin
                    lengthen();
                    scan_mode = M_FRAC;
                    taken     = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_num(c)) begin
                    lengthen();
                    taken = 1'b1;
                end
            end
            M_LT, M_GT, M_EQ, M_BANG: begin
                if (c == 8'h3D) begin
                    put_token(pair_op(scan_mode), tok_start, 8'd2);
                    taken = 1'b1;
                end
            end
            M_AMP: begin
                if (c == 8'h26) begin
                    put_token(K_ANDAND, tok_start, 8'd2);
                    taken = 1'b1;
                end
            end
            M_BAR: begin
                if (c == 8'h7C) begin
                    put_token(K_OROR, tok_start, 8'd2);
                    taken = 1'b1;
                end
            end
            default: scan_mode = M_IDLE;
        endcase

        if (taken) begin
            if (scan_mode >= M_LT) begin
                scan_mode = M_IDLE;
                tok_len   = '0;
            end
        end else begin
            close_token();
            if (c == 8'h00) begin
                put_token(K_END, byte_pos, 8'd0);
                clear_scan();
                ended = 1'b1;
            end else if (is_blank(c)) begin
            end else if (is_alpha(c)) begin
                open_token(M_IDENT);
                if (c == 8'h69)
                    kw_seen = KW_I;
                else if (c == 8'h65)
                    kw_seen = KW_E;
                else if (c == 8'h72)
                    kw_seen = KW_R;
            end else if (is_num(c)) begin
                open_token(M_INT);
            end else if (c == 8'h3C) begin
                open_token(M_LT);
            end else if (c == 8'h3E) begin
                open_token(M_GT);
            end else if (c == 8'h3D) begin
                open_token(M_EQ);
            end else if (c == 8'h21) begin
                open_token(M_BANG);
            end else if (c == 8'h26) begin
                open_token(M_AMP);
            end else if (c == 8'h7C) begin
                open_token(M_BAR);
            end else begin
                put_token(single_op(c), byte_pos, 8'd1);
            end
        end

        if (!ended && byte_pos != 16'hFFFF)
            byte_pos++;
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[k])
            tokens_due.push_back(step_tokens[k]);
    endtask

    task automatic flag_token(input string what, input t_res got, input t_res want);
        $write("%0t %s: kind %0d start %0d len %0d last %0b,",
               $time, what, got.tok.kind, got.tok.start, got.tok.len, got.last);
        $display(" due kind %0d start %0d len %0d last %0b",
                 want.tok.kind, want.tok.start, want.tok.len, want.last);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            clear_scan();
            tokens_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got.tok.kind  = t_kind'(i_token_kind);
                got.tok.start = i_token_start;
                got.tok.len   = i_token_length;
                got.last      = i_last_of_run;
                if (tokens_due.size() == 0) begin
                    flag_token("token with none due", got, '0);
                end else begin
                    want = tokens_due.pop_front();
                    if (got.tok.kind !== want.tok.kind || got.tok.start !== want.tok.start
                        || got.tok.len !== want.tok.len || got.last !== want.last)
                        flag_token("token differs", got, want);
                end
            end
            if (i_push && !i_full)
                scan_char(i_text_byte);
        end
        o_tokens_due = tokens_due.size();
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives source text into the expression lexer and drains its tokens under
// changing idle patterns, with one long hold on the token side. Starts with
// keywords, paired operators, a lone bar, a doubled fraction dot and
// invalid bytes, then random token text with noise, a token longer than
// the length limit and a short statement, and more random text.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic [7:0]  text_byte   = 8'h00;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;
    int          mismatches;
    int          tokens_due;
    int          send_idle   = 0;
    int          recv_idle   = 0;
    int          sent        = 0;
    logic        long_hold   = 1'b0;

    string kw_words[12] = '{"if", "else", "return", "i", "el", "ret", "iff",
                            "elsewhere", "returns", "r", "e", "retur"};
    string op_words[22] = '{"<=", ">=", "==", "!=", "&&", "||", "<", ">", "=", "!",
                            ";", ",", "/", "-", "+", "*", "{", "}", "(", ")",
                            "&", "|"};
    logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0A, 8'h0D};

    expression_lexer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_byte    (text_byte),
        .push           (push),
        .full           (full),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (token_kind),
        .o_token_start  (token_start),
        .o_token_length (token_length),
        .o_last_of_run  (last_of_run)
    );

    token_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_byte    (text_byte),
        .i_push         (push),
        .i_full         (full),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_token_kind   (token_kind),
        .i_token_start  (token_start),
        .i_token_length (token_length),
        .i_last_of_run  (last_of_run),
        .o_mismatches   (mismatches),
        .o_tokens_due   (tokens_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // token side: random idling, plus one long hold while text keeps coming
    initial begin : drain
        int held;
        logic hold_done;
        held      = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                pop <= 1'b0;
                held++;
                if (held == 300)
                    hold_done = 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        text_byte <= c;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k]);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = lead ? $urandom_range(52) : $urandom_range(62);
        if (r < 26)
            return 8'(8'h61 + r);
        else if (r < 52)
            return 8'(8'h41 + r - 26);
        else if (r == 52)
            return 8'h5F;
        else
            return 8'(8'h30 + r - 53);
    endfunction

    task automatic send_piece();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(99) < 35) begin
                send_text(kw_words[$urandom_range(11)]);
            end else begin
                n = $urandom_range(1, 8);
                send_char(word_char(1'b1));
                for (int k = 1; k < n; k++)
                    send_char(word_char(1'b0));
            end
        end else if (pick < 45) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                send_char(8'(8'h30 + $urandom_range(9)));
            if ($urandom_range(99) < 40) begin
                send_char(8'h2E);
                n = $urandom_range(0, 3);
                for (int k = 0; k < n; k++)
                    send_char(8'(8'h30 + $urandom_range(9)));
                if ($urandom_range(99) < 15)
                    send_char(8'h2E);
            end
        end else if (pick < 75) begin
            send_text(op_words[$urandom_range(21)]);
        end else if (pick < 90) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                send_char(blank_chars[$urandom_range(5)]);
        end else if (pick < 97) begin
            send_char(8'($urandom_range(1, 255)));
        end else begin
            send_char(8'h00);
        end
    endtask

    task automatic send_pieces(input int upto);
        while (sent < upto)
            send_piece();
    endtask

    initial begin : stimulus
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle = 35;
        recv_idle = 78;
        send_text("if==else!=return<=7.5.&&|");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(8'h00);
        long_hold = 1'b1;
        send_pieces(250);

        send_idle = 78;
        recv_idle = 35;
        send_pieces(480);

        // overlong identifier, then a short statement
        send_idle = 0;
        recv_idle = 0;
        send_char(8'h00);
        send_char(8'h61);
        for (int k = 1; k < 300; k++)
            send_char(word_char(1'b0));
        send_text("x<=1.5;return");
        send_char(8'h00);
        send_pieces(850);
        send_char(8'h00);
        push <= 1'b0;

        wait (tokens_due == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/elx_pkg.sv
rtl/elx_fifo.sv
rtl/elx_front.sv
rtl/elx_back.sv
rtl/expression_lexer.sv
verif/token_checker.sv
verif/testbench.sv
